// ===== src/vfvf_pkg.sv =====
// Shared widths, latencies, types and helpers for the vector field voxel feature pipeline.
`default_nettype none

package vfvf_pkg;

  // Word format
  localparam int WORD_W   = 32;
  localparam int FRAC_W   = 16;
  localparam int NUM_IN   = 12;
  localparam int IN_W     = NUM_IN * WORD_W;

  // Result field widths
  localparam int DIR_W    = FRAC_W + 2;
  localparam int MAG_W    = WORD_W - 1;
  localparam int GROW_W   = FRAC_W + 2;
  localparam int OUT_BITS = 7 * WORD_W + 3 * DIR_W + MAG_W + GROW_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // Length and direction datapath
  localparam int SQ_W      = 2 * WORD_W;
  localparam int DQ_W      = 2 * FRAC_W + 1;
  localparam int DIV_STEPS = DQ_W;
  localparam int DSQ_STEPS = FRAC_W + 1;
  localparam int DSR_W     = DQ_W + 2;
  localparam int MSQ_STEPS = WORD_W;
  localparam int MSR_W     = SQ_W + 2;

  // Determinant datapath
  localparam int PROD_W     = 2 * WORD_W;
  localparam int MINOR_W    = 2 * WORD_W + 1;
  localparam int MHI_W      = MINOR_W - WORD_W;
  localparam int PP_W       = WORD_W + MHI_W;
  localparam int TERM_W     = PP_W + WORD_W;
  localparam int DET_W      = 3 * WORD_W + 3;
  localparam int GD_W       = 4 * FRAC_W + 2;
  localparam int GDIV_STEPS = FRAC_W + 1;

  // Stage counts measured from the input register
  localparam int NORM_LAT = 3 + DIV_STEPS + DSQ_STEPS;
  localparam int MAG_PAD  = NORM_LAT - 3 - MSQ_STEPS;
  localparam int DET_LAT  = 7 + GDIV_STEPS;
  localparam int GROW_PAD = NORM_LAT - DET_LAT;

  typedef logic [2:0][WORD_W-1:0] word3_t;
  typedef logic [8:0][WORD_W-1:0] jac_t;
  typedef logic [2:0][DIR_W-1:0]  dir3_t;

  // Fields that ride alongside the long datapaths
  typedef struct packed {
    logic [WORD_W-1:0] curl_z;
    logic [WORD_W-1:0] curl_y;
    logic [WORD_W-1:0] curl_x;
    logic [WORD_W-1:0] divergence;
    word3_t            vec;
  } side_t;

  // Clamp a widened sum to the signed word range
  function automatic logic [WORD_W-1:0] sat_word(input logic signed [WORD_W+1:0] x);
    logic signed [WORD_W+1:0] hi;
    logic signed [WORD_W+1:0] lo;
    hi = {3'b000, {(WORD_W-1){1'b1}}};
    lo = {3'b111, {(WORD_W-1){1'b0}}};
    if (x > hi) begin
      return hi[WORD_W-1:0];
    end else if (x < lo) begin
      return lo[WORD_W-1:0];
    end
    return x[WORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/vfvf_norm.sv =====
// Vector length and unit direction: squares, long division and digit-by-digit square roots.
`default_nettype none

module vfvf_norm (
  input  logic                        clk,
  input  logic                        ce,
  input  vfvf_pkg::word3_t            vec,
  output vfvf_pkg::dir3_t             dir,
  output logic [vfvf_pkg::MAG_W-1:0]  magnitude
);
  import vfvf_pkg::*;

  // One restoring division step: shift in a numerator bit, subtract when it fits
  function automatic logic [SQ_W+DQ_W-1:0] div_step(input logic [SQ_W-1:0] r,
                                                    input logic nb,
                                                    input logic [SQ_W-1:0] d,
                                                    input logic [DQ_W-1:0] q);
    logic [SQ_W:0] rr;
    rr = {r, nb};
    if (rr >= {1'b0, d}) begin
      rr = rr - {1'b0, d};
      return {q[DQ_W-2:0], 1'b1, rr[SQ_W-1:0]};
    end
    return {q[DQ_W-2:0], 1'b0, rr[SQ_W-1:0]};
  endfunction

  // One square root digit for the direction root
  function automatic logic [DSQ_STEPS+DSR_W-1:0] dsq_step(input logic [DSR_W-1:0] rem,
                                                           input logic [DSQ_STEPS-1:0] q,
                                                           input int b);
    logic [DSR_W-1:0] trial;
    trial = (DSR_W'(q) << (b + 1)) + (DSR_W'(1) << (2 * b));
    if (trial <= rem) begin
      return {q | (DSQ_STEPS'(1) << b), rem - trial};
    end
    return {q, rem};
  endfunction

  // One square root digit for the length root
  function automatic logic [MSQ_STEPS+MSR_W-1:0] msq_step(input logic [MSR_W-1:0] rem,
                                                           input logic [MSQ_STEPS-1:0] q,
                                                           input int b);
    logic [MSR_W-1:0] trial;
    trial = (MSR_W'(q) << (b + 1)) + (MSR_W'(1) << (2 * b));
    if (trial <= rem) begin
      return {q | (MSQ_STEPS'(1) << b), rem - trial};
    end
    return {q, rem};
  endfunction

  logic [2:0][SQ_W-1:0]      sq1;
  logic [2:0]                sg1;
  logic [SQ_W-1:0]           s2;
  logic [2:0][SQ_W-1:0]      sq2;
  logic [2:0]                sg2;
  logic                      z2;

  logic [2:0][SQ_W-1:0]      dr  [DIV_STEPS];
  logic [2:0][DQ_W-1:0]      dq  [DIV_STEPS];
  logic [SQ_W-1:0]           ds  [DIV_STEPS];
  logic [2:0]                dsg [DIV_STEPS];
  logic                      dz  [DIV_STEPS];

  logic [2:0][DSR_W-1:0]     tr  [DSQ_STEPS];
  logic [2:0][DSQ_STEPS-1:0] tq  [DSQ_STEPS];
  logic [2:0]                tsg [DSQ_STEPS];
  logic                      tz  [DSQ_STEPS];

  logic [MSR_W-1:0]          mr  [MSQ_STEPS];
  logic [MSQ_STEPS-1:0]      mq  [MSQ_STEPS];
  logic [MAG_W-1:0]          mag_dly [MAG_PAD+1];

  // Square each component, then sum
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        sq1[i] <= $signed(vec[i]) * $signed(vec[i]);
        sg1[i] <= vec[i][WORD_W-1];
      end
      s2  <= sq1[0] + sq1[1] + sq1[2];
      sq2 <= sq1;
      sg2 <= sg1;
      z2  <= ((sq1[0] | sq1[1] | sq1[2]) == '0);
    end
  end

  // Divide v_i^2 * 2^(2F) by the sum of squares, one quotient bit per stage
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        {dq[0][i], dr[0][i]} <= div_step({1'b0, sq2[i][SQ_W-1:1]}, sq2[i][0], s2, '0);
      end
      ds[0]  <= s2;
      dsg[0] <= sg2;
      dz[0]  <= z2;
      for (int k = 1; k < DIV_STEPS; k++) begin
        for (int i = 0; i < 3; i++) begin
          {dq[k][i], dr[k][i]} <= div_step(dr[k-1][i], 1'b0, ds[k-1], dq[k-1][i]);
        end
        ds[k]  <= ds[k-1];
        dsg[k] <= dsg[k-1];
        dz[k]  <= dz[k-1];
      end
    end
  end

  // Take the square root of each quotient, one digit per stage
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        {tq[0][i], tr[0][i]} <= dsq_step(DSR_W'(dq[DIV_STEPS-1][i]), '0, DSQ_STEPS - 1);
      end
      tsg[0] <= dsg[DIV_STEPS-1];
      tz[0]  <= dz[DIV_STEPS-1];
      for (int j = 1; j < DSQ_STEPS; j++) begin
        for (int i = 0; i < 3; i++) begin
          {tq[j][i], tr[j][i]} <= dsq_step(tr[j-1][i], tq[j-1][i], DSQ_STEPS - 1 - j);
        end
        tsg[j] <= tsg[j-1];
        tz[j]  <= tz[j-1];
      end
    end
  end

  // Apply the sign, force zero for a zero vector
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        if (tz[DSQ_STEPS-1]) begin
          dir[i] <= '0;
        end else if (tsg[DSQ_STEPS-1][i]) begin
          dir[i] <= -DIR_W'(tq[DSQ_STEPS-1][i]);
        end else begin
          dir[i] <= DIR_W'(tq[DSQ_STEPS-1][i]);
        end
      end
    end
  end

  // Length root, saturate, then hold until the direction is ready
  always_ff @(posedge clk) begin
    if (ce) begin
      {mq[0], mr[0]} <= msq_step(MSR_W'(s2), '0, MSQ_STEPS - 1);
      for (int j = 1; j < MSQ_STEPS; j++) begin
        {mq[j], mr[j]} <= msq_step(mr[j-1], mq[j-1], MSQ_STEPS - 1 - j);
      end
      if (mq[MSQ_STEPS-1][MSQ_STEPS-1]) begin
        mag_dly[0] <= '1;
      end else begin
        mag_dly[0] <= mq[MSQ_STEPS-1][MAG_W-1:0];
      end
      for (int p = 1; p <= MAG_PAD; p++) begin
        mag_dly[p] <= mag_dly[p-1];
      end
    end
  end

  assign magnitude = mag_dly[MAG_PAD];

endmodule

`default_nettype wire

// ===== src/vfvf_det.sv =====
// Jacobian determinant and the growth measure derived from its absolute value.
`default_nettype none

module vfvf_det (
  input  logic                        clk,
  input  logic                        ce,
  input  vfvf_pkg::jac_t              jac,
  output logic [vfvf_pkg::GROW_W-1:0] growth
);
  import vfvf_pkg::*;

  logic signed [PROD_W-1:0]  p   [6];
  logic signed [WORD_W-1:0]  c1  [3];
  logic signed [WORD_W-1:0]  c2  [3];
  logic signed [MINOR_W-1:0] mn  [3];
  logic signed [PP_W-1:0]    pl  [3];
  logic signed [PP_W-1:0]    ph  [3];
  logic signed [TERM_W-1:0]  tm  [3];
  logic signed [DET_W-1:0]   det;
  logic [DET_W-1:0]          mag_det;

  logic                      big;
  logic [GROW_W-1:0]         gs;
  logic [GD_W-1:0]           dv;

  logic [GD_W-1:0]           gr  [GDIV_STEPS];
  logic [GDIV_STEPS-1:0]     gq  [GDIV_STEPS];
  logic [GD_W-1:0]           gd  [GDIV_STEPS];
  logic                      gb  [GDIV_STEPS];
  logic [GROW_W-1:0]         ggs [GDIV_STEPS];

  // One step of 2^(4F) / |det|; the numerator has no ones below the start point
  function automatic logic [GDIV_STEPS+GD_W-1:0] gdiv_step(input logic [GD_W-1:0] r,
                                                           input logic [GD_W-1:0] d,
                                                           input logic [GDIV_STEPS-1:0] q);
    logic [GD_W:0] rr;
    rr = {r, 1'b0};
    if (rr >= {1'b0, d}) begin
      rr = rr - {1'b0, d};
      return {q[GDIV_STEPS-2:0], 1'b1, rr[GD_W-1:0]};
    end
    return {q[GDIV_STEPS-2:0], 1'b0, rr[GD_W-1:0]};
  endfunction

  assign mag_det = det[DET_W-1] ? DET_W'(-det) : DET_W'(det);

  // Cofactor products, minors, split wide products, terms, determinant, growth inputs
  always_ff @(posedge clk) begin
    if (ce) begin
      p[0] <= $signed(jac[4]) * $signed(jac[8]);
      p[1] <= $signed(jac[7]) * $signed(jac[5]);
      p[2] <= $signed(jac[1]) * $signed(jac[8]);
      p[3] <= $signed(jac[7]) * $signed(jac[2]);
      p[4] <= $signed(jac[1]) * $signed(jac[5]);
      p[5] <= $signed(jac[4]) * $signed(jac[2]);
      c1[0] <= $signed(jac[0]);
      c1[1] <= $signed(jac[3]);
      c1[2] <= $signed(jac[6]);
      for (int k = 0; k < 3; k++) begin
        mn[k] <= p[2*k] - p[2*k+1];
        c2[k] <= c1[k];
        pl[k] <= c2[k] * $signed({1'b0, mn[k][WORD_W-1:0]});
        ph[k] <= c2[k] * $signed(mn[k][MINOR_W-1:WORD_W]);
        tm[k] <= $signed({ph[k], {WORD_W{1'b0}}}) + pl[k];
      end
      det <= tm[0] - tm[1] + tm[2];
      big <= (mag_det > (DET_W'(1) << (3 * FRAC_W)));
      gs  <= GROW_W'(mag_det[2*FRAC_W +: FRAC_W+1]) - (GROW_W'(1) << FRAC_W);
      dv  <= (|mag_det[DET_W-1:GD_W]) ? '1 : mag_det[GD_W-1:0];
    end
  end

  // Reciprocal of a large determinant, one quotient bit per stage
  always_ff @(posedge clk) begin
    if (ce) begin
      {gq[0], gr[0]} <= gdiv_step(GD_W'(1) << (3 * FRAC_W - 1), dv, '0);
      gd[0]  <= dv;
      gb[0]  <= big;
      ggs[0] <= gs;
      for (int k = 1; k < GDIV_STEPS; k++) begin
        {gq[k], gr[k]} <= gdiv_step(gr[k-1], gd[k-1], gq[k-1]);
        gd[k]  <= gd[k-1];
        gb[k]  <= gb[k-1];
        ggs[k] <= ggs[k-1];
      end
      if (gb[GDIV_STEPS-1]) begin
        growth <= (GROW_W'(1) << FRAC_W) - GROW_W'(gq[GDIV_STEPS-1]);
      end else begin
        growth <= ggs[GDIV_STEPS-1];
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/vector_field_voxel_features.sv =====
// Top level: stream ports, input register, divergence and curl, result alignment.
// One voxel enters per clock and its twelve features pass through one input register
// plus 53 pipeline stages before they leave. The depth is
// set by the direction path: a 33-stage restoring divider followed by a 17-stage
// square root, one bit per stage. Every other feature is delayed to line up with
// it. The whole pipeline holds while a result waits on m_axis_tready.
`default_nettype none

module vector_field_voxel_features (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // vec_x, vec_y, vec_z, dxdx, dydx, dzdx, dxdy, dydy, dzdy, dxdz, dydz, dzdz
  input  logic [vfvf_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // out_x, out_y, out_z, dir_x, dir_y, dir_z, magnitude, growth, divergence,
  // curl_x, curl_y, curl_z, one zero pad bit
  output logic [vfvf_pkg::OUT_W-1:0]  m_axis_tdata
);
  import vfvf_pkg::*;

  localparam logic [GROW_W-1:0] GROW_ONE = GROW_W'(1) << FRAC_W;

  logic              ce;
  logic [IN_W-1:0]   in_r;
  logic              vld [NORM_LAT+1];
  word3_t            vec;
  jac_t              jac;
  side_t             side [NORM_LAT];
  dir3_t             dir;
  logic [MAG_W-1:0]  magnitude;
  logic [GROW_W-1:0] growth_raw;
  logic [GROW_W-1:0] g_dly [GROW_PAD];
  logic [GROW_W-1:0] growth;
  side_t             side_out;

  // Advance everything unless a finished result is stalled
  assign ce            = !vld[NORM_LAT] || m_axis_tready;
  assign s_axis_tready = ce;
  assign m_axis_tvalid = vld[NORM_LAT];

  assign vec = in_r[3*WORD_W-1:0];
  assign jac = in_r[IN_W-1:3*WORD_W];

  // Capture the transaction
  always_ff @(posedge clk) begin
    if (ce) begin
      in_r <= s_axis_tdata;
    end
  end

  // Move valid bits along with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= NORM_LAT; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (ce) begin
      vld[0] <= s_axis_tvalid;
      for (int k = 1; k <= NORM_LAT; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  // Compute trace and curl, then hold them alongside the long paths
  always_ff @(posedge clk) begin
    if (ce) begin
      side[0].vec        <= vec;
      side[0].divergence <= sat_word($signed({{2{jac[0][WORD_W-1]}}, jac[0]})
                                   + $signed({{2{jac[4][WORD_W-1]}}, jac[4]})
                                   + $signed({{2{jac[8][WORD_W-1]}}, jac[8]}));
      side[0].curl_x     <= sat_word($signed({{2{jac[5][WORD_W-1]}}, jac[5]})
                                   - $signed({{2{jac[7][WORD_W-1]}}, jac[7]}));
      side[0].curl_y     <= sat_word($signed({{2{jac[6][WORD_W-1]}}, jac[6]})
                                   - $signed({{2{jac[2][WORD_W-1]}}, jac[2]}));
      side[0].curl_z     <= sat_word($signed({{2{jac[1][WORD_W-1]}}, jac[1]})
                                   - $signed({{2{jac[3][WORD_W-1]}}, jac[3]}));
      for (int k = 1; k < NORM_LAT; k++) begin
        side[k] <= side[k-1];
      end
      g_dly[0] <= growth_raw;
      for (int k = 1; k < GROW_PAD; k++) begin
        g_dly[k] <= g_dly[k-1];
      end
    end
  end

  vfvf_norm u_norm (
    .clk       (clk),
    .ce        (ce),
    .vec       (vec),
    .dir       (dir),
    .magnitude (magnitude)
  );

  vfvf_det u_det (
    .clk    (clk),
    .ce     (ce),
    .jac    (jac),
    .growth (growth_raw)
  );

  assign growth   = g_dly[GROW_PAD-1];
  assign side_out = side[NORM_LAT-1];

  assign m_axis_tdata = {{(OUT_W-OUT_BITS){1'b0}},
                         side_out.curl_z, side_out.curl_y, side_out.curl_x,
                         side_out.divergence, growth, magnitude, dir, side_out.vec};

  // Checks
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_no_idle_block: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked while output is empty");

  a_growth_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($signed(growth) <= $signed(GROW_ONE))
                   && ($signed(growth) >= -$signed(GROW_ONE)))
    else $error("growth outside -1.0 .. 1.0");

  a_zero_vector: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (side_out.vec == '0)) |-> ((magnitude == '0) && (dir == '0)))
    else $error("zero vector with nonzero length or direction");

endmodule

`default_nettype wire
